@@ hdl/arp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_pkg: shared types and constants of the advertisement record parser
// Field layout of the summary, the queue entry, result kinds and phase codes.
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam int unsigned HASH_BYTES  = 3;
    localparam int unsigned TOKEN_BYTES = 2;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 104;
    localparam int unsigned M_TUSER_W = 2;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_COMPLETE  = 2'd1,
        KIND_TRUNCATED = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_HASH    = 5'b00010,
        PH_LENGTH  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_TAIL    = 5'b10000
    } t_phase;

    // Progress through the bytes that follow the payload
    localparam logic [1:0] TAIL_NONE  = 2'd0;
    localparam logic [1:0] TAIL_TOKEN = 2'd1;
    localparam logic [1:0] TAIL_EXTRA = 2'd2;

    typedef struct packed {
        logic [7:0]  extra_value;
        logic        extra_present;
        logic [15:0] token_value;
        logic        token_present;
        logic [31:0] payload_length;
        logic [23:0] hash_value;
        logic        fast_flag;
        logic [2:0]  sock_ver;
        logic [2:0]  version;
    } t_summary;

    // One accepted byte produces at most a payload result and a summary
    typedef struct packed {
        logic       pay_vld;
        logic [7:0] pay_byte;
        logic       sum_vld;
        logic       sum_done;
        t_summary   sum;
    } t_entry;

endpackage

@@ hdl/advert_record_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// advert_record_parser: streaming parser for advertisement records
// Takes one record byte per transaction, passes payload bytes out and ends
// each record with a summary result carrying the decoded header fields.
// ----------------------------------------------------------------------------
// The block accepts one byte every clock cycle while the result queue has
// room. Each byte is parsed combinationally into a two-entry result queue; a
// byte normally yields one result at most, but the final byte of a record
// inside the payload yields a payload result and then the summary, which
// leave the output one after the other. The queue absorbs that second result,
// so input only stalls when the byte right after such a byte also yields a
// result (a record of a single byte), or when the output side holds off.
// Each result is registered in the queue before it is shown at the output.
module advert_record_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [arp_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [7:0] in_byte
    input  logic                            s_axis_tlast,  // end_of_record
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] payload_byte, [10:8] version, [13:11] sock_ver,
    // [14] fast_flag, [38:15] hash_value, [70:39] payload_length,
    // [71] token_present, [87:72] token_value, [88] extra_present,
    // [96:89] extra_value, [103:97] zero
    output logic [arp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [arp_pkg::M_TUSER_W-1:0]   m_axis_tuser,  // [1:0] kind
    output logic                            m_axis_tlast   // run_last
);
    import arp_pkg::*;

    // Parse state
    t_phase      r_phase,      n_phase;
    logic [31:0] r_byte_count, n_byte_count;
    logic [6:0]  r_hdr,        n_hdr;
    logic [23:0] r_hash,       n_hash;
    logic [31:0] r_len,        n_len;
    logic [15:0] r_token,      n_token;
    logic [7:0]  r_extra,      n_extra;
    logic [1:0]  r_tail_cnt,   n_tail_cnt;

    // Result queue
    t_entry      r_fifo [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic        r_sub;

    logic        s_accept;
    logic        s_last;
    logic [7:0]  s_byte;
    logic [31:0] s_inc;
    logic [31:0] s_new_len;
    logic        s_done;
    t_entry      s_entry;
    logic        s_push;
    t_entry      s_head;
    logic        s_show_pay;
    logic        s_last_res;
    logic        s_pop;

    assign s_byte   = s_axis_tdata[7:0];
    assign s_last   = s_axis_tlast;
    assign s_axis_tready = (r_cnt != 2'd2);
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign s_inc    = r_byte_count + 32'd1;
    assign s_new_len = {r_len[23:0], s_byte};

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_hdr        = r_hdr;
        n_hash       = r_hash;
        n_len        = r_len;
        n_token      = r_token;
        n_extra      = r_extra;
        n_tail_cnt   = r_tail_cnt;
        unique case (r_phase)
            PH_HEADER: begin
                n_byte_count = '0;
                n_hdr        = s_byte[7:1];
                n_hash       = '0;
                n_len        = '0;
                n_token      = '0;
                n_extra      = '0;
                n_tail_cnt   = TAIL_NONE;
                n_phase      = s_byte[1] ? PH_LENGTH : PH_HASH;
            end
            PH_HASH: begin
                n_hash       = {r_hash[15:0], s_byte};
                n_byte_count = s_inc;
                if (s_inc >= 32'(HASH_BYTES)) begin
                    n_byte_count = '0;
                    n_phase      = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                n_len        = s_new_len;
                n_byte_count = s_inc;
                if (s_inc >= (r_hdr[0] ? 32'd1 : 32'd4)) begin
                    n_byte_count = '0;
                    n_phase      = (s_new_len == 32'd0) ? PH_TAIL : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_byte_count = s_inc;
                if (s_inc >= r_len) begin
                    n_byte_count = '0;
                    n_phase      = PH_TAIL;
                end
            end
            PH_TAIL: begin
                if (r_tail_cnt == TAIL_NONE) begin
                    n_token      = {r_token[7:0], s_byte};
                    n_byte_count = s_inc;
                    if (s_inc >= 32'(TOKEN_BYTES)) begin
                        n_tail_cnt = TAIL_TOKEN;
                    end
                end else if (r_tail_cnt == TAIL_TOKEN) begin
                    n_extra    = s_byte;
                    n_tail_cnt = TAIL_EXTRA;
                end
            end
            default: begin
                n_phase      = PH_HEADER;
                n_byte_count = '0;
                n_hdr        = '0;
                n_hash       = '0;
                n_len        = '0;
                n_token      = '0;
                n_extra      = '0;
                n_tail_cnt   = TAIL_NONE;
            end
        endcase
    end

    // Build the queue entry from the updated state
    assign s_done = (n_phase == PH_TAIL);

    always_comb begin
        s_entry.pay_vld  = (r_phase == PH_PAYLOAD);
        s_entry.pay_byte = s_byte;
        s_entry.sum_vld  = s_last;
        s_entry.sum_done = s_done;
        s_entry.sum.version        = n_hdr[6:4];
        s_entry.sum.sock_ver       = n_hdr[3:1];
        s_entry.sum.fast_flag      = n_hdr[0];
        s_entry.sum.hash_value     = n_hash;
        s_entry.sum.payload_length = n_len;
        s_entry.sum.token_present  = s_done && (n_tail_cnt != TAIL_NONE);
        s_entry.sum.token_value    = s_entry.sum.token_present ? n_token : 16'd0;
        s_entry.sum.extra_present  = s_done && (n_tail_cnt == TAIL_EXTRA);
        s_entry.sum.extra_value    = s_entry.sum.extra_present ? n_extra : 8'd0;
    end

    assign s_push = s_accept && (s_entry.pay_vld || s_entry.sum_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_byte_count <= '0;
            r_hdr        <= '0;
            r_hash       <= '0;
            r_len        <= '0;
            r_token      <= '0;
            r_extra      <= '0;
            r_tail_cnt   <= TAIL_NONE;
        end else if (s_accept) begin
            if (s_last) begin
                // Record ends: drop everything and wait for the next header
                r_phase      <= PH_HEADER;
                r_byte_count <= '0;
                r_hdr        <= '0;
                r_hash       <= '0;
                r_len        <= '0;
                r_token      <= '0;
                r_extra      <= '0;
                r_tail_cnt   <= TAIL_NONE;
            end else begin
                r_phase      <= n_phase;
                r_byte_count <= n_byte_count;
                r_hdr        <= n_hdr;
                r_hash       <= n_hash;
                r_len        <= n_len;
                r_token      <= n_token;
                r_extra      <= n_extra;
                r_tail_cnt   <= n_tail_cnt;
            end
        end
    end

    // Output side: an entry gives its payload result first, then its summary
    assign s_head     = r_fifo[r_rd_ptr];
    assign s_show_pay = s_head.pay_vld && !r_sub;
    assign s_last_res = !s_show_pay || !s_head.sum_vld;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign s_pop      = m_axis_tvalid && m_axis_tready && s_last_res;
    assign m_axis_tlast = s_last_res;

    always_comb begin
        if (s_show_pay) begin
            m_axis_tdata = {96'd0, s_head.pay_byte};
            m_axis_tuser = KIND_PAYLOAD;
        end else begin
            m_axis_tdata = {7'd0, s_head.sum, 8'd0};
            m_axis_tuser = s_head.sum_done ? KIND_COMPLETE : KIND_TRUNCATED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_fifo[r_wr_ptr] <= s_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
            r_sub    <= 1'b0;
        end else begin
            if (s_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (s_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (s_pop && !s_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
            // Hold the sub-index until the entry's last result has gone
            if (m_axis_tvalid && m_axis_tready) begin
                r_sub <= !s_last_res;
            end
        end
    end

endmodule
